/* hdl/rhm_pkg.sv */
// ----------------------------------------------------------------------------
// Rolling hash matcher package
// Sizes, codes, payload and controller/datapath command and status types.
// ----------------------------------------------------------------------------
`default_nettype none

package rhm_pkg;

    localparam int NEEDLES    = 8;
    localparam int MAX_NEEDLE = 256;
    localparam int HASH_BITS  = 64;

    localparam int SLOT_W     = $clog2(NEEDLES);
    localparam int OFS_W      = $clog2(MAX_NEEDLE);
    localparam int LEN_W      = OFS_W + 1;
    localparam int NADDR_W    = SLOT_W + OFS_W;
    localparam int HALF_W     = HASH_BITS / 2;
    localparam int POS_W      = 32;
    localparam int ID_W       = 16;
    localparam int MCNT_W     = 16;
    localparam int STAT_W     = 3;
    localparam int MINLEN_W   = 9;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 64;

    localparam logic [STAT_W-1:0] ST_MATCH  = 3'd0;
    localparam logic [STAT_W-1:0] ST_ACCEPT = 3'd1;
    localparam logic [STAT_W-1:0] ST_SHORT  = 3'd2;
    localparam logic [STAT_W-1:0] ST_LONG   = 3'd3;
    localparam logic [STAT_W-1:0] ST_DUP    = 3'd4;

    localparam logic [CFG_ADDR_W-1:0] CFG_MIN_LEN = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_FACTOR  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_LIMIT   = 2'd2;

    localparam logic [MINLEN_W-1:0]  RST_MIN_LEN = 9'd8;
    localparam logic [HASH_BITS-1:0] RST_FACTOR  = 64'd257;
    localparam logic [MCNT_W-1:0]    RST_LIMIT   = 16'd0;

    typedef enum logic [1:0] {
        MSEL_ELIM,
        MSEL_LOAD,
        MSEL_HAY
    } msel_t;

    typedef struct packed {
        logic              req_type;
        logic [7:0]        data_byte;
        logic [SLOT_W-1:0] slot;
        logic [ID_W-1:0]   item_id;
        logic              first;
        logic              last;
    } req_pay_t;

    typedef struct packed {
        logic  accept;
        logic  cfg_write;
        logic  elim_init;
        logic  elim_upd;
        logic  mul_start;
        msel_t mul_sel;
        logic  lchk;
        logic  lh_init;
        logic  lh_rd;
        logic  lh_acc;
        logic  ldup;
        logic  h_rd;
        logic  h_sub;
        logic  h_upd;
        logic  hchk;
        logic  v_rd;
        logic  v_cmp;
        logic  res_load;
    } cmd_t;

    typedef struct packed {
        logic is_load;
        logic is_last;
        logic mul_done;
        logic mul_busy;
        logic cnt_one;
        logic len_short;
        logic len_long;
        logic hit_ok;
        logic v_match;
        logic v_last;
        logic out_free;
    } stat_t;

endpackage

`default_nettype wire

/* hdl/rhm_if.sv */
// ----------------------------------------------------------------------------
// Rolling hash matcher channels
// Request, result and register write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface rhm_req_if
    import rhm_pkg::*;
    ();
    logic              valid;
    logic              ready;
    logic              req_type;
    logic [7:0]        data_byte;
    logic [SLOT_W-1:0] slot;
    logic [ID_W-1:0]   item_id;
    logic              first;
    logic              last;

    modport source (output valid, req_type, data_byte, slot, item_id, first, last,
                    input ready);
    modport sink   (input valid, req_type, data_byte, slot, item_id, first, last,
                    output ready);
endinterface

interface rhm_res_if
    import rhm_pkg::*;
    ();
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [POS_W-1:0]  match_start;
    logic [ID_W-1:0]   pattern_id;

    modport source (output valid, status, match_start, pattern_id, input ready);
    modport sink   (input valid, status, match_start, pattern_id, output ready);
endinterface

interface rhm_cfg_if
    import rhm_pkg::*;
    ();
    logic                  valid;
    logic                  ready;
    logic [CFG_ADDR_W-1:0] addr;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, addr, data, input ready);
    modport sink   (input valid, addr, data, output ready);
endinterface

`default_nettype wire

/* hdl/rhm_mul.sv */
// ----------------------------------------------------------------------------
// Rolling hash matcher multiplier
// Low half of a wide product from three half-width partial products.
// ----------------------------------------------------------------------------
`default_nettype none

module rhm_mul
    import rhm_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic [HASH_BITS-1:0] a,
    input  wire logic [HASH_BITS-1:0] b,
    output logic      [HASH_BITS-1:0] p,
    output logic                      done,
    output logic                      busy
);

    typedef enum logic [4:0] {
        P_IDLE = 5'b00001,
        P_LL   = 5'b00010,
        P_LH   = 5'b00100,
        P_HL   = 5'b01000,
        P_SUM  = 5'b10000
    } mphase_t;

    mphase_t              phase_reg, phase_next;
    logic                 done_reg, done_next;
    logic [HASH_BITS-1:0] a_reg, a_next;
    logic [HASH_BITS-1:0] b_reg, b_next;
    logic [HASH_BITS-1:0] prod_reg, prod_next;
    logic [HASH_BITS-1:0] acc_reg, acc_next;

    always_comb
    begin
        phase_next = phase_reg;
        done_next  = 1'b0;
        a_next     = a_reg;
        b_next     = b_reg;
        prod_next  = prod_reg;
        acc_next   = acc_reg;
        unique case (phase_reg)
            P_IDLE:
            begin
                if (start)
                begin
                    a_next     = a;
                    b_next     = b;
                    phase_next = P_LL;
                end
            end
            P_LL:
            begin
                prod_next  = a_reg[HALF_W-1:0] * b_reg[HALF_W-1:0];
                phase_next = P_LH;
            end
            P_LH:
            begin
                acc_next   = prod_reg;
                prod_next  = a_reg[HALF_W-1:0] * b_reg[HASH_BITS-1:HALF_W];
                phase_next = P_HL;
            end
            P_HL:
            begin
                acc_next   = acc_reg + {prod_reg[HALF_W-1:0], {HALF_W{1'b0}}};
                prod_next  = a_reg[HASH_BITS-1:HALF_W] * b_reg[HALF_W-1:0];
                phase_next = P_SUM;
            end
            P_SUM:
            begin
                acc_next   = acc_reg + {prod_reg[HALF_W-1:0], {HALF_W{1'b0}}};
                done_next  = 1'b1;
                phase_next = P_IDLE;
            end
            default:
            begin
                phase_next = P_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= P_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg    <= a_next;
        b_reg    <= b_next;
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

    assign p    = acc_reg;
    assign done = done_reg;
    assign busy = (phase_reg != P_IDLE);

endmodule

`default_nettype wire

/* hdl/rhm_datapath.sv */
// ----------------------------------------------------------------------------
// Rolling hash matcher datapath
// Registers, needle and history memories, hashing and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rhm_datapath
    import rhm_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire cmd_t                  cmd,
    output stat_t                      stat,
    input  wire req_pay_t              req_pay,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  out_ready,
    output logic                       out_valid,
    output logic      [STAT_W-1:0]     out_status,
    output logic      [POS_W-1:0]      out_start,
    output logic      [ID_W-1:0]       out_id
);

    logic [MINLEN_W-1:0]  min_len_reg, min_len_next;
    logic [HASH_BITS-1:0] factor_reg, factor_next;
    logic [MCNT_W-1:0]    limit_reg, limit_next;

    req_pay_t             pay_reg, pay_next;
    logic [LEN_W-1:0]     nlen_reg [NEEDLES];
    logic [LEN_W-1:0]     nlen_next [NEEDLES];
    logic [ID_W-1:0]      tag_reg [NEEDLES];
    logic [ID_W-1:0]      tag_next [NEEDLES];
    logic [HASH_BITS-1:0] tab_reg [NEEDLES];
    logic [HASH_BITS-1:0] tab_next [NEEDLES];
    logic [NEEDLES-1:0]   valid_reg, valid_next;

    logic [HASH_BITS-1:0] wh_reg, wh_next;
    logic [HASH_BITS-1:0] lh_reg, lh_next;
    logic [HASH_BITS-1:0] elim_reg, elim_next;
    logic [HASH_BITS-1:0] sub_reg, sub_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [MCNT_W-1:0]    mcnt_reg, mcnt_next;
    logic [OFS_W-1:0]     hwr_reg, hwr_next;
    logic [LEN_W-1:0]     cnt_reg, cnt_next;
    logic [OFS_W-1:0]     k_reg, k_next;
    logic [OFS_W-1:0]     vk_reg, vk_next;
    logic [SLOT_W-1:0]    hit_reg, hit_next;
    logic [LEN_W-1:0]     vlen_reg, vlen_next;

    logic [STAT_W-1:0]    pst_reg, pst_next;
    logic [POS_W-1:0]     pstart_reg, pstart_next;
    logic [ID_W-1:0]      pid_reg, pid_next;
    logic                 ov_reg, ov_next;
    logic [STAT_W-1:0]    ost_reg, ost_next;
    logic [POS_W-1:0]     ostart_reg, ostart_next;
    logic [ID_W-1:0]      oid_reg, oid_next;

    logic [7:0]           hist_mem [MAX_NEEDLE];
    logic [7:0]           hist_q;
    logic [7:0]           nst_mem [NEEDLES*MAX_NEEDLE];
    logic [7:0]           nst_q;

    logic [LEN_W-1:0]     eff_m;
    logic [LEN_W-1:0]     len_cur;
    logic                 nst_we;
    logic [NADDR_W-1:0]   nst_waddr;
    logic                 nst_re;
    logic [NADDR_W-1:0]   nst_raddr;
    logic                 hist_re;
    logic [OFS_W-1:0]     hist_raddr;
    logic [HASH_BITS-1:0] mul_a;
    logic [HASH_BITS-1:0] mul_p;
    logic                 mul_done;
    logic                 mul_busy;
    logic                 dup;
    logic                 found;
    logic [SLOT_W-1:0]    hit_j;
    logic                 limited;

    rhm_mul u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.mul_start),
        .a     (mul_a),
        .b     (factor_reg),
        .p     (mul_p),
        .done  (mul_done),
        .busy  (mul_busy)
    );

    always_comb
    begin
        if (min_len_reg == '0)
            eff_m = LEN_W'(1);
        else if (min_len_reg > MINLEN_W'(MAX_NEEDLE))
            eff_m = LEN_W'(MAX_NEEDLE);
        else
            eff_m = LEN_W'(min_len_reg);
    end

    always_comb
    begin
        unique case (cmd.mul_sel)
            MSEL_LOAD: mul_a = lh_reg;
            MSEL_HAY:  mul_a = wh_reg;
            default:   mul_a = elim_reg;
        endcase
    end

    assign len_cur   = req_pay.first ? '0 : nlen_reg[req_pay.slot];
    assign nst_we    = cmd.accept && !req_pay.req_type && (len_cur < LEN_W'(MAX_NEEDLE));
    assign nst_waddr = {req_pay.slot, len_cur[OFS_W-1:0]};
    assign nst_re    = cmd.lh_rd || cmd.v_rd;
    assign nst_raddr = cmd.v_rd ? {hit_reg, vk_reg} : {pay_reg.slot, k_reg};
    assign hist_re   = cmd.h_rd || cmd.v_rd;
    assign hist_raddr = cmd.v_rd ? OFS_W'(hwr_reg - vlen_reg[OFS_W-1:0] + vk_reg)
                                 : OFS_W'(hwr_reg - eff_m[OFS_W-1:0]);

    always_comb
    begin
        dup = 1'b0;
        for (int j = 0; j < NEEDLES; j++)
        begin
            if ((SLOT_W'(j) != pay_reg.slot) && valid_reg[j] && (tab_reg[j] == lh_reg))
                dup = 1'b1;
        end
    end

    always_comb
    begin
        found = 1'b0;
        hit_j = '0;
        for (int j = NEEDLES - 1; j >= 0; j--)
        begin
            if (valid_reg[j] && (tab_reg[j] == wh_reg))
            begin
                found = 1'b1;
                hit_j = SLOT_W'(j);
            end
        end
    end

    assign limited = (limit_reg != '0) && (mcnt_reg >= limit_reg);

    always_comb
    begin
        min_len_next = min_len_reg;
        factor_next  = factor_reg;
        limit_next   = limit_reg;
        pay_next     = pay_reg;
        nlen_next    = nlen_reg;
        tag_next     = tag_reg;
        tab_next     = tab_reg;
        valid_next   = valid_reg;
        wh_next      = wh_reg;
        lh_next      = lh_reg;
        elim_next    = elim_reg;
        sub_next     = sub_reg;
        pos_next     = pos_reg;
        mcnt_next    = mcnt_reg;
        hwr_next     = hwr_reg;
        cnt_next     = cnt_reg;
        k_next       = k_reg;
        vk_next      = vk_reg;
        hit_next     = hit_reg;
        vlen_next    = vlen_reg;
        pst_next     = pst_reg;
        pstart_next  = pstart_reg;
        pid_next     = pid_reg;
        ov_next      = ov_reg;
        ost_next     = ost_reg;
        ostart_next  = ostart_reg;
        oid_next     = oid_reg;

        if (cmd.cfg_write)
        begin
            unique case (cfg_addr)
                CFG_MIN_LEN: min_len_next = cfg_data[MINLEN_W-1:0];
                CFG_FACTOR:  factor_next  = cfg_data[HASH_BITS-1:0];
                CFG_LIMIT:   limit_next   = cfg_data[MCNT_W-1:0];
                default:     ;
            endcase
        end

        if (cmd.accept)
        begin
            pay_next = req_pay;
            if (!req_pay.req_type)
            begin
                valid_next[req_pay.slot] = 1'b0;
                tag_next[req_pay.slot]   = req_pay.item_id;
                if (len_cur < LEN_W'(MAX_NEEDLE))
                    nlen_next[req_pay.slot] = len_cur + LEN_W'(1);
                else
                    nlen_next[req_pay.slot] = LEN_W'(MAX_NEEDLE + 1);
            end
            else if (req_pay.first)
            begin
                wh_next   = '0;
                pos_next  = '0;
                mcnt_next = '0;
            end
        end

        if (cmd.elim_init)
        begin
            elim_next = HASH_BITS'(1);
            cnt_next  = eff_m;
        end
        if (cmd.elim_upd)
        begin
            elim_next = mul_p;
            cnt_next  = cnt_reg - LEN_W'(1);
        end

        if (cmd.lchk)
        begin
            pst_next    = stat.len_short ? ST_SHORT : ST_LONG;
            pstart_next = '0;
            pid_next    = pay_reg.item_id;
        end
        if (cmd.lh_init)
        begin
            lh_next  = '0;
            k_next   = OFS_W'(nlen_reg[pay_reg.slot] - eff_m);
            cnt_next = eff_m;
        end
        if (cmd.lh_acc)
        begin
            lh_next  = mul_p + HASH_BITS'(nst_q);
            k_next   = k_reg + OFS_W'(1);
            cnt_next = cnt_reg - LEN_W'(1);
        end
        if (cmd.ldup)
        begin
            pstart_next = '0;
            pid_next    = pay_reg.item_id;
            if (dup)
                pst_next = ST_DUP;
            else
            begin
                pst_next                 = ST_ACCEPT;
                tab_next[pay_reg.slot]   = lh_reg;
                valid_next[pay_reg.slot] = 1'b1;
            end
        end

        if (cmd.h_sub)
            sub_next = elim_reg * HASH_BITS'(hist_q);
        if (cmd.h_upd)
        begin
            if (pos_reg >= POS_W'(eff_m))
                wh_next = mul_p + HASH_BITS'(pay_reg.data_byte) - sub_reg;
            else
                wh_next = mul_p + HASH_BITS'(pay_reg.data_byte);
            hwr_next = hwr_reg + OFS_W'(1);
            if (pos_reg != '1)
                pos_next = pos_reg + POS_W'(1);
        end

        if (cmd.hchk)
        begin
            hit_next  = hit_j;
            vlen_next = nlen_reg[hit_j];
            vk_next   = '0;
        end
        if (cmd.v_cmp)
        begin
            vk_next = vk_reg + OFS_W'(1);
            if (stat.v_match && stat.v_last)
            begin
                if (mcnt_reg != '1)
                    mcnt_next = mcnt_reg + MCNT_W'(1);
                pst_next    = ST_MATCH;
                pstart_next = pos_reg - POS_W'(vlen_reg);
                pid_next    = tag_reg[hit_reg];
            end
        end

        if (cmd.res_load)
        begin
            ov_next     = 1'b1;
            ost_next    = pst_reg;
            ostart_next = pstart_reg;
            oid_next    = pid_reg;
        end
        else if (out_ready)
            ov_next = 1'b0;
    end

    always_comb
    begin
        stat.is_load   = !pay_reg.req_type;
        stat.is_last   = pay_reg.last;
        stat.mul_done  = mul_done;
        stat.mul_busy  = mul_busy;
        stat.cnt_one   = (cnt_reg == LEN_W'(1));
        stat.len_short = (nlen_reg[pay_reg.slot] < eff_m);
        stat.len_long  = (nlen_reg[pay_reg.slot] > LEN_W'(MAX_NEEDLE));
        stat.hit_ok    = found && !limited && (pos_reg >= POS_W'(eff_m))
                         && (POS_W'(nlen_reg[hit_j]) <= pos_reg)
                         && (nlen_reg[hit_j] <= LEN_W'(MAX_NEEDLE));
        stat.v_match   = (hist_q == nst_q);
        stat.v_last    = (vk_reg == OFS_W'(vlen_reg - LEN_W'(1)));
        stat.out_free  = !ov_reg || out_ready;
    end

    always_ff @(posedge clk)
    begin
        if (nst_we)
            nst_mem[nst_waddr] <= req_pay.data_byte;
        if (nst_re)
            nst_q <= nst_mem[nst_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.h_upd)
            hist_mem[hwr_reg] <= pay_reg.data_byte;
        if (hist_re)
            hist_q <= hist_mem[hist_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_len_reg <= RST_MIN_LEN;
            factor_reg  <= RST_FACTOR;
            limit_reg   <= RST_LIMIT;
            for (int j = 0; j < NEEDLES; j++)
            begin
                nlen_reg[j] <= '0;
                tag_reg[j]  <= '0;
                tab_reg[j]  <= '0;
            end
            valid_reg <= '0;
            wh_reg    <= '0;
            lh_reg    <= '0;
            pos_reg   <= '0;
            mcnt_reg  <= '0;
            hwr_reg   <= '0;
            cnt_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            min_len_reg <= min_len_next;
            factor_reg  <= factor_next;
            limit_reg   <= limit_next;
            nlen_reg    <= nlen_next;
            tag_reg     <= tag_next;
            tab_reg     <= tab_next;
            valid_reg   <= valid_next;
            wh_reg      <= wh_next;
            lh_reg      <= lh_next;
            pos_reg     <= pos_next;
            mcnt_reg    <= mcnt_next;
            hwr_reg     <= hwr_next;
            cnt_reg     <= cnt_next;
            ov_reg      <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pay_reg    <= pay_next;
        elim_reg   <= elim_next;
        sub_reg    <= sub_next;
        k_reg      <= k_next;
        vk_reg     <= vk_next;
        hit_reg    <= hit_next;
        vlen_reg   <= vlen_next;
        pst_reg    <= pst_next;
        pstart_reg <= pstart_next;
        pid_reg    <= pid_next;
        ost_reg    <= ost_next;
        ostart_reg <= ostart_next;
        oid_reg    <= oid_next;
    end

    assign out_valid  = ov_reg;
    assign out_status = ost_reg;
    assign out_start  = ostart_reg;
    assign out_id     = oid_reg;

endmodule

`default_nettype wire

/* hdl/rhm_ctrl.sv */
// ----------------------------------------------------------------------------
// Rolling hash matcher controller
// Sequences power computation, needle hashing, window update and verify.
// ----------------------------------------------------------------------------
`default_nettype none

module rhm_ctrl
    import rhm_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire logic  cfg_valid,
    output logic       cfg_ready,
    input  wire stat_t stat,
    output cmd_t       cmd
);

    typedef enum logic [12:0] {
        S_ELIM_INIT = 13'b0000000000001,
        S_ELIM_MUL  = 13'b0000000000010,
        S_ELIM_WAIT = 13'b0000000000100,
        S_IDLE      = 13'b0000000001000,
        S_DISP      = 13'b0000000010000,
        S_LRD       = 13'b0000000100000,
        S_LWAIT     = 13'b0000001000000,
        S_LDUP      = 13'b0000010000000,
        S_HWAIT     = 13'b0000100000000,
        S_HCHK      = 13'b0001000000000,
        S_VRD       = 13'b0010000000000,
        S_VCMP      = 13'b0100000000000,
        S_RESP      = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;

    assign cfg_ready = (state_reg == S_IDLE);
    assign in_ready  = (state_reg == S_IDLE) && !cfg_valid;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_ELIM_INIT:
            begin
                cmd.elim_init = 1'b1;
                state_next    = S_ELIM_MUL;
            end
            S_ELIM_MUL:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = MSEL_ELIM;
                state_next    = S_ELIM_WAIT;
            end
            S_ELIM_WAIT:
            begin
                if (stat.mul_done)
                begin
                    cmd.elim_upd = 1'b1;
                    state_next   = stat.cnt_one ? S_IDLE : S_ELIM_MUL;
                end
            end
            S_IDLE:
            begin
                if (cfg_valid)
                begin
                    cmd.cfg_write = 1'b1;
                    state_next    = S_ELIM_INIT;
                end
                else if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                priority if (stat.is_load && !stat.is_last)
                    state_next = S_IDLE;
                else if (stat.is_load && (stat.len_short || stat.len_long))
                begin
                    cmd.lchk   = 1'b1;
                    state_next = S_RESP;
                end
                else if (stat.is_load)
                begin
                    cmd.lh_init = 1'b1;
                    state_next  = S_LRD;
                end
                else
                begin
                    cmd.h_rd      = 1'b1;
                    cmd.mul_start = 1'b1;
                    cmd.mul_sel   = MSEL_HAY;
                    state_next    = S_HWAIT;
                end
            end
            S_LRD:
            begin
                cmd.lh_rd     = 1'b1;
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = MSEL_LOAD;
                state_next    = S_LWAIT;
            end
            S_LWAIT:
            begin
                if (stat.mul_done)
                begin
                    cmd.lh_acc = 1'b1;
                    state_next = stat.cnt_one ? S_LDUP : S_LRD;
                end
            end
            S_LDUP:
            begin
                cmd.ldup   = 1'b1;
                state_next = S_RESP;
            end
            S_HWAIT:
            begin
                cmd.h_sub = 1'b1;
                if (stat.mul_done)
                begin
                    cmd.h_upd  = 1'b1;
                    state_next = S_HCHK;
                end
            end
            S_HCHK:
            begin
                cmd.hchk   = 1'b1;
                state_next = stat.hit_ok ? S_VRD : S_IDLE;
            end
            S_VRD:
            begin
                cmd.v_rd   = 1'b1;
                state_next = S_VCMP;
            end
            S_VCMP:
            begin
                cmd.v_cmp = 1'b1;
                priority if (!stat.v_match)
                    state_next = S_IDLE;
                else if (stat.v_last)
                    state_next = S_RESP;
                else
                    state_next = S_VRD;
            end
            S_RESP:
            begin
                if (stat.out_free)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_ELIM_INIT;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

/* hdl/rolling_hash_multi_pattern_match.sv */
// ----------------------------------------------------------------------------
// Rolling hash multi-pattern matcher
// One request at a time; a result waits in one output register.
// Needle byte: stored; the last reports a too short or long needle, else hashes
// the last min_len bytes: accept or duplicate. Haystack byte: hash update, hit
// verified bytewise, match reported. Reset and each register write rebuild the
// hash power (shared 4-step multiplier); no request or write taken meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module rolling_hash_multi_pattern_match
    import rhm_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    rhm_req_if.sink   req,
    rhm_res_if.source res,
    rhm_cfg_if.sink   cfg
);

    cmd_t     cmd;
    stat_t    stat;
    req_pay_t pay;
    logic     in_ready;
    logic     cfg_ready;

    assign pay.req_type  = req.req_type;
    assign pay.data_byte = req.data_byte;
    assign pay.slot      = req.slot;
    assign pay.item_id   = req.item_id;
    assign pay.first     = req.first;
    assign pay.last      = req.last;

    assign req.ready = in_ready;
    assign cfg.ready = cfg_ready;

    rhm_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (in_ready),
        .cfg_valid (cfg.valid),
        .cfg_ready (cfg_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    rhm_datapath u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .req_pay    (pay),
        .cfg_addr   (cfg.addr),
        .cfg_data   (cfg.data),
        .out_ready  (res.ready),
        .out_valid  (res.valid),
        .out_status (res.status),
        .out_start  (res.match_start),
        .out_id     (res.pattern_id)
    );

`ifndef NO_ASSERTIONS
    a_no_dual_accept: assert property (@(posedge clk) disable iff (!rst_n)
        !(req.valid && in_ready && cfg.valid && cfg_ready))
        else $error("request and register write taken together");

    a_res_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_load |-> stat.out_free)
        else $error("result loaded over a pending result");

    a_mul_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mul_start |-> !stat.mul_busy)
        else $error("multiplier started while busy");
`endif

endmodule

`default_nettype wire
